/* design/itb_pkg.sv */
// ----------------------------------------------------------------------------
// itb_pkg
// Shared types and constants for the interval timer bank.
// ----------------------------------------------------------------------------
package itb_pkg;

    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
    localparam int IDX_MAX_W = 6;
    localparam int S_TDATA_W = 200;
    localparam int M_TDATA_W = 216;

    typedef enum logic [1:0] {
        FN_TICK = 2'd0,
        FN_SET  = 2'd1,
        FN_READ = 2'd2,
        FN_NONE = 2'd3
    } func_t;

    typedef struct packed {
        func_t                  func;
        logic                   in_range;
        logic [IDX_MAX_W-1:0]   idx;
        logic [63:0]            now_ns;
        logic                   absolute;
        logic [33:0]            value_sec;
        logic [29:0]            value_nsec;
        logic [33:0]            reload_sec;
        logic [29:0]            reload_nsec;
    } cmd_t;

    typedef struct packed {
        logic        status;
        logic [63:0] tick_count;
        logic [15:0] fired_mask;
        logic [34:0] old_reload_sec;
        logic [29:0] old_reload_nsec;
        logic [34:0] old_expiry_sec;
        logic [29:0] old_expiry_nsec;
    } res_t;

endpackage

/* design/interval_timer_bank_unit.sv */
// ----------------------------------------------------------------------------
// interval_timer_bank_unit
// Bank of nanosecond interval timers with tick, set and read operations.
// ----------------------------------------------------------------------------
// One word in gives one word out. A tick scans the bank one timer per clock;
// a set runs a shared 18x30 multiplier over five steps, then splits the old
// interval and the old expiry into seconds by a reciprocal multiply, one
// after the other; a read, a set of an out-of-range timer or an unused code
// goes straight to the output register.
// A two-word input queue lets new words arrive while an operation runs, and
// the output register holds a finished word while the next one executes.
// ----------------------------------------------------------------------------
module interval_timer_bank_unit
    import itb_pkg::*;
#(
    parameter int NUM_TIMERS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // timer_index, now_ns, absolute, value_sec, value_nsec, reload_sec, reload_nsec
    input  logic [S_TDATA_W-1:0] s_tdata,
    // func
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // tick_count, fired_mask, old_reload_sec, old_reload_nsec,
    // old_expiry_sec, old_expiry_nsec
    output logic [M_TDATA_W-1:0] m_tdata,
    // status
    output logic                 m_tuser
);

    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    itb_front #(.NUM_TIMERS(NUM_TIMERS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    itb_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* design/itb_front.sv */
// ----------------------------------------------------------------------------
// itb_front
// Accepts input words, decodes the operation and index check, and queues them.
// ----------------------------------------------------------------------------
module itb_front
    import itb_pkg::*;
#(
    parameter int NUM_TIMERS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [1:0]           s_tuser,
    output logic                 q_valid,
    input  logic                 q_ready,
    output cmd_t                 q_cmd
);

    cmd_t       fifo_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    cmd_t       cmd_in;
    logic       push;
    logic       pop;

    always_comb
    begin
        cmd_in.func        = func_t'(s_tuser);
        cmd_in.idx         = IDX_MAX_W'(s_tdata[3:0]);
        cmd_in.in_range    = ({3'b000, s_tdata[3:0]} < 7'(NUM_TIMERS));
        cmd_in.now_ns      = s_tdata[67:4];
        cmd_in.absolute    = s_tdata[68];
        cmd_in.value_sec   = s_tdata[102:69];
        cmd_in.value_nsec  = s_tdata[132:103];
        cmd_in.reload_sec  = s_tdata[166:133];
        cmd_in.reload_nsec = s_tdata[196:167];
    end

    assign s_tready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_cmd    = fifo_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2) else $error("queue count overflow");
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");
    a_one_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with single entry");

endmodule

/* design/itb_div.sv */
// ----------------------------------------------------------------------------
// itb_div
// Divides a 64-bit value by one second in nanoseconds. A reciprocal multiply
// on one 32x32 multiplier gives a quotient that is at most one short, and a
// single compare and subtract then corrects it.
// ----------------------------------------------------------------------------
module itb_div
    import itb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    output logic        busy,
    output logic        done,
    output logic [34:0] quotient,
    output logic [29:0] remainder
);

    // floor(2^64 / 1000000000)
    localparam logic [34:0] RECIP     = 35'd18446744073;
    localparam logic [3:0]  LAST_STEP = 4'd8;

    logic [63:0] x_reg;
    logic [98:0] acc_reg;
    logic [63:0] prod_reg;
    logic [34:0] q_reg;
    logic [63:0] r_reg;
    logic [3:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;

    assign mul_p     = {32'd0, mul_a} * {32'd0, mul_b};
    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg[29:0];

    always_comb
    begin
        case (step_reg)
            4'd0:
            begin
                mul_a = x_reg[31:0];
                mul_b = RECIP[31:0];
            end
            4'd1:
            begin
                mul_a = x_reg[63:32];
                mul_b = RECIP[31:0];
            end
            4'd2:
            begin
                mul_a = x_reg[31:0];
                mul_b = {29'd0, RECIP[34:32]};
            end
            4'd3:
            begin
                mul_a = x_reg[63:32];
                mul_b = {29'd0, RECIP[34:32]};
            end
            4'd5:
            begin
                mul_a = q_reg[31:0];
                mul_b = {2'b00, NS_PER_SEC};
            end
            4'd6:
            begin
                mul_a = {29'd0, q_reg[34:32]};
                mul_b = {2'b00, NS_PER_SEC};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            x_reg <= dividend;
        end
        else if (busy_reg)
        begin
            case (step_reg)
                4'd0:       acc_reg  <= {35'd0, mul_p};
                4'd1, 4'd2: acc_reg  <= acc_reg + {3'd0, mul_p, 32'd0};
                4'd3:       acc_reg  <= acc_reg + {mul_p[34:0], 64'd0};
                4'd4:       q_reg    <= acc_reg[98:64];
                4'd5:       prod_reg <= mul_p;
                4'd6:       prod_reg <= prod_reg + {mul_p[31:0], 32'd0};
                4'd7:       r_reg    <= x_reg - prod_reg;
                4'd8:
                begin
                    // estimate is short by at most one second
                    if (r_reg >= {34'd0, NS_PER_SEC})
                    begin
                        q_reg <= q_reg + 35'd1;
                        r_reg <= r_reg - {34'd0, NS_PER_SEC};
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == LAST_STEP);
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    step_reg <= step_reg + 4'd1;
                end
            end
        end
    end

endmodule

/* design/itb_back.sv */
// ----------------------------------------------------------------------------
// itb_back
// Executes queued operations against the timer state and holds the result.
// ----------------------------------------------------------------------------
module itb_back
    import itb_pkg::*;
#(
    parameter int NUM_TIMERS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  cmd_t                 q_cmd,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tuser
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_MUL, S_DIV, S_WRITE, S_OUT
    } state_t;

    state_t      state_reg;
    logic [63:0] expiry_reg [NUM_TIMERS];
    logic [63:0] reload_reg [NUM_TIMERS];
    logic [63:0] count_reg  [NUM_TIMERS];
    cmd_t        cmd_reg;
    res_t        res_reg;
    logic [IDX_W-1:0] scan_reg;
    logic [2:0]  step_reg;
    logic [47:0] prod_reg;
    logic [63:0] acc_v_reg;
    logic [63:0] acc_r_reg;
    logic [63:0] old_i_reg;
    logic [63:0] old_e_reg;
    logic        div_sel_reg;
    logic        div_run_reg;
    logic        m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic        m_tuser_reg;

    logic [IDX_W-1:0] q_idx;
    logic [IDX_W-1:0] c_idx;
    logic [17:0] mul_a;
    logic        div_start;
    logic        div_busy;
    logic        div_done;
    logic [34:0] div_q;
    logic [29:0] div_r;
    logic [63:0] e_cur;
    logic        due;
    logic [63:0] rearm;
    logic        out_load;
    res_t        read_res;

    assign q_idx   = q_cmd.idx[IDX_W-1:0];
    assign c_idx   = cmd_reg.idx[IDX_W-1:0];
    assign q_ready = (state_reg == S_IDLE);
    assign e_cur   = expiry_reg[scan_reg];
    assign due     = (e_cur != 64'd0) && (cmd_reg.now_ns >= e_cur);
    assign rearm   = (reload_reg[scan_reg] != 64'd0) ?
                     (cmd_reg.now_ns + reload_reg[scan_reg]) : 64'd0;
    assign div_start = (state_reg == S_DIV) && !div_run_reg;
    assign out_load  = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    always_comb
    begin
        case (step_reg[1:0])
            2'd0:    mul_a = {2'b00, cmd_reg.value_sec[15:0]};
            2'd1:    mul_a = cmd_reg.value_sec[33:16];
            2'd2:    mul_a = {2'b00, cmd_reg.reload_sec[15:0]};
            default: mul_a = cmd_reg.reload_sec[33:16];
        endcase
    end

    always_comb
    begin
        read_res = '0;
        if (!q_cmd.in_range || count_reg[q_idx] == 64'd0)
        begin
            read_res.status = 1'b1;
        end
        else
        begin
            read_res.tick_count = count_reg[q_idx];
        end
    end

    itb_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_sel_reg ? old_e_reg : old_i_reg),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            div_run_reg  <= 1'b0;
            div_sel_reg  <= 1'b0;
            scan_reg     <= '0;
            step_reg     <= '0;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                expiry_reg[i] <= '0;
                reload_reg[i] <= '0;
                count_reg[i]  <= '0;
            end
        end
        else
        begin
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg   <= q_cmd;
                        res_reg   <= (q_cmd.func == FN_READ) ? read_res : '0;
                        scan_reg  <= '0;
                        step_reg  <= '0;
                        acc_v_reg <= {34'd0, q_cmd.value_nsec};
                        acc_r_reg <= {34'd0, q_cmd.reload_nsec};
                        old_i_reg <= reload_reg[q_idx];
                        old_e_reg <= expiry_reg[q_idx];
                        div_sel_reg <= 1'b0;
                        case (q_cmd.func)
                            FN_TICK: state_reg <= S_SCAN;
                            FN_SET:  state_reg <= q_cmd.in_range ? S_MUL : S_OUT;
                            FN_READ:
                            begin
                                if (!read_res.status)
                                begin
                                    count_reg[q_idx] <= '0;
                                end
                                state_reg <= S_OUT;
                            end
                            default: state_reg <= S_OUT;
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (due)
                    begin
                        count_reg[scan_reg]  <= count_reg[scan_reg] + 64'd1;
                        expiry_reg[scan_reg] <= rearm;
                        res_reg.fired_mask   <= res_reg.fired_mask
                                                | (16'd1 << scan_reg);
                    end
                    if (scan_reg == IDX_W'(NUM_TIMERS - 1))
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + IDX_W'(1);
                    end
                end
                S_MUL:
                begin
                    // each product is registered in prod_reg before it is folded into the sums
                    prod_reg <= {30'd0, mul_a} * {18'd0, NS_PER_SEC};
                    case (step_reg)
                        3'd1: acc_v_reg <= acc_v_reg + {16'd0, prod_reg};
                        3'd2: acc_v_reg <= acc_v_reg + {prod_reg, 16'd0};
                        3'd3: acc_r_reg <= acc_r_reg + {16'd0, prod_reg};
                        3'd4: acc_r_reg <= acc_r_reg + {prod_reg, 16'd0};
                        default: ;
                    endcase
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd4)
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (!div_run_reg)
                    begin
                        div_run_reg <= 1'b1;
                    end
                    else if (div_done)
                    begin
                        div_run_reg <= 1'b0;
                        if (!div_sel_reg)
                        begin
                            res_reg.old_reload_sec  <= div_q;
                            res_reg.old_reload_nsec <= div_r;
                            div_sel_reg <= 1'b1;
                        end
                        else
                        begin
                            res_reg.old_expiry_sec  <= div_q;
                            res_reg.old_expiry_nsec <= div_r;
                            state_reg <= S_WRITE;
                        end
                    end
                end
                S_WRITE:
                begin
                    if (cmd_reg.value_sec == 34'd0 && cmd_reg.value_nsec == 30'd0)
                    begin
                        expiry_reg[c_idx] <= '0;
                    end
                    else if (cmd_reg.absolute)
                    begin
                        expiry_reg[c_idx] <= acc_v_reg;
                    end
                    else
                    begin
                        expiry_reg[c_idx] <= cmd_reg.now_ns + acc_v_reg;
                    end
                    reload_reg[c_idx] <= acc_r_reg;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tuser_reg <= res_reg.status;
            m_tdata_reg <= {6'd0, res_reg.old_expiry_nsec, res_reg.old_expiry_sec,
                            res_reg.old_reload_nsec, res_reg.old_reload_sec,
                            res_reg.fired_mask, res_reg.tick_count};
        end
    end

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (step_reg <= 3'd4)) else $error("multiply step overrun");
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |-> !div_busy) else $error("write while divider busy");
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy) else $error("divider restarted while busy");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && q_ready) |=> (state_reg != S_IDLE)) else $error("popped word lost");

endmodule

/* dv/interval_timer_bank_unit_tb.sv */
// ----------------------------------------------------------------------------
// interval_timer_bank_unit_tb
// Self-checking stream testbench for the interval timer bank.
// ----------------------------------------------------------------------------
// A queue of timer operations feeds a bursty driver. Every accepted word
// updates a local copy of the bank and queues the expected reply. A monitor
// with its own stall pattern compares each reply field by field. Stimulus
// starts with directed cases (due and not-yet-due timers, disarm by zero value,
// wrap to zero, out-of-range nanoseconds, unused code) and then random traffic
// that advances a running clock so that timers keep firing.
// ----------------------------------------------------------------------------
module interval_timer_bank_unit_tb;
    import itb_pkg::*;

    localparam int  NTIM       = 16;
    localparam int  LIMIT      = 1000000;
    localparam int  DRAIN      = 300;
    localparam int  NUM_RANDOM = 730;

    typedef struct {
        func_t       fn;
        logic [3:0]  idx;
        logic [63:0] now;
        logic        abs_t;
        logic [33:0] vsec;
        logic [29:0] vnsec;
        logic [33:0] rsec;
        logic [29:0] rnsec;
    } timer_op_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    timer_op_t   pending_ops[$];
    res_t        expected_replies[$];
    timer_op_t   held_op;
    logic [63:0] bank_expiry[NTIM];
    logic [63:0] bank_reload[NTIM];
    logic [63:0] bank_count[NTIM];
    int          errors;
    int          replies_seen;
    int          cycles;
    int          burst_left;
    int          gap_left;
    int          stall_mode;
    int          mode_left;
    logic        hold_off;

    interval_timer_bank_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic logic [63:0] sec_nsec_to_ns(logic [33:0] sec, logic [29:0] nsec);
        return {30'd0, sec} * 64'd1000000000 + {34'd0, nsec};
    endfunction

    // Update the local bank and return the reply the block should give.
    function automatic res_t apply_timer_op(timer_op_t op);
        res_t        r;
        logic [63:0] oi;
        logic [63:0] oe;
        r = '0;
        case (op.fn)
            FN_TICK:
            begin
                for (int i = 0; i < NTIM; i++)
                begin
                    if (bank_expiry[i] != 0 && op.now >= bank_expiry[i])
                    begin
                        bank_count[i] += 64'd1;
                        bank_expiry[i] = (bank_reload[i] != 0) ? op.now + bank_reload[i]
                                                               : 64'd0;
                        r.fired_mask[i] = 1'b1;
                    end
                end
            end
            FN_SET:
            begin
                oi = bank_reload[op.idx];
                oe = bank_expiry[op.idx];
                r.old_reload_sec  = 35'(oi / 64'd1000000000);
                r.old_reload_nsec = 30'(oi % 64'd1000000000);
                r.old_expiry_sec  = 35'(oe / 64'd1000000000);
                r.old_expiry_nsec = 30'(oe % 64'd1000000000);
                if (op.vsec == 0 && op.vnsec == 0)
                    bank_expiry[op.idx] = 64'd0;
                else if (op.abs_t)
                    bank_expiry[op.idx] = sec_nsec_to_ns(op.vsec, op.vnsec);
                else
                    bank_expiry[op.idx] = op.now + sec_nsec_to_ns(op.vsec, op.vnsec);
                bank_reload[op.idx] = sec_nsec_to_ns(op.rsec, op.rnsec);
            end
            FN_READ:
            begin
                if (bank_count[op.idx] == 0)
                    r.status = 1'b1;
                else
                begin
                    r.tick_count = bank_count[op.idx];
                    bank_count[op.idx] = 64'd0;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report(string field, logic [63:0] got, logic [63:0] want);
        errors++;
        if (errors <= 40)
            $display("mismatch on reply %0d, %s: got %0h, want %0h",
                     replies_seen, field, got, want);
    endtask

    task automatic add_op(func_t fn, logic [3:0] idx, logic [63:0] now, logic abs_t,
                          logic [33:0] vsec, logic [29:0] vnsec,
                          logic [33:0] rsec, logic [29:0] rnsec);
        timer_op_t op;
        op.fn = fn; op.idx = idx; op.now = now; op.abs_t = abs_t;
        op.vsec = vsec; op.vnsec = vnsec; op.rsec = rsec; op.rnsec = rnsec;
        pending_ops.push_back(op);
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= FN_NONE;
            burst_left <= 1;
            gap_left   <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_replies.push_back(apply_timer_op(held_op));
            if (s_tvalid && !s_tready)
                ;
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_ops.size() > 0)
            begin
                held_op = pending_ops.pop_front();
                s_tdata <= {3'd0, held_op.rnsec, held_op.rsec, held_op.vnsec, held_op.vsec,
                            held_op.abs_t, held_op.now, held_op.idx};
                s_tuser  <= held_op.fn;
                s_tvalid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: stall pattern switches between always ready, light and heavy.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_mode <= 0;
            mode_left  <= 50;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                mode_left  <= $urandom_range(20, 400);
            end
            else
                mode_left <= mode_left - 1;
            if (hold_off)
                m_tready <= 1'b0;
            else if (stall_mode == 0)
                m_tready <= 1'b1;
            else if (stall_mode == 1)
                m_tready <= ($urandom_range(0, 3) != 0);
            else
                m_tready <= ($urandom_range(0, 4) == 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_replies.size() == 0)
                report("unexpected word", m_tdata[63:0], 64'd0);
            else
            begin
                res_t want;
                want = expected_replies.pop_front();
                if (m_tuser !== want.status)
                    report("status", 64'(m_tuser), 64'(want.status));
                if (m_tdata[63:0] !== want.tick_count)
                    report("tick_count", m_tdata[63:0], want.tick_count);
                if (m_tdata[79:64] !== want.fired_mask)
                    report("fired_mask", 64'(m_tdata[79:64]), 64'(want.fired_mask));
                if (m_tdata[114:80] !== want.old_reload_sec)
                    report("old_reload_sec", 64'(m_tdata[114:80]), 64'(want.old_reload_sec));
                if (m_tdata[144:115] !== want.old_reload_nsec)
                    report("old_reload_nsec", 64'(m_tdata[144:115]),
                           64'(want.old_reload_nsec));
                if (m_tdata[179:145] !== want.old_expiry_sec)
                    report("old_expiry_sec", 64'(m_tdata[179:145]), 64'(want.old_expiry_sec));
                if (m_tdata[209:180] !== want.old_expiry_nsec)
                    report("old_expiry_nsec", 64'(m_tdata[209:180]),
                           64'(want.old_expiry_nsec));
            end
            replies_seen++;
        end
    end

    // Long hold-off on the output while the sender keeps pushing.
    initial
    begin
        hold_off <= 1'b0;
        wait (replies_seen >= 100);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (3000) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    logic [63:0] run_ns;
    logic [63:0] wrap_iv;
    int          pick;

    initial
    begin
        errors = 0;
        replies_seen = 0;
        cycles = 0;
        for (int i = 0; i < NTIM; i++)
        begin
            bank_expiry[i] = '0;
            bank_reload[i] = '0;
            bank_count[i]  = '0;
        end

        // due exactly at expiry, before it, and rearm by interval
        add_op(FN_SET, 4'd0, 64'd10, 1'b1, 34'd0, 30'd100, 34'd0, 30'd50);
        add_op(FN_TICK, 4'd0, 64'd99, 1'b0, '0, '0, '0, '0);
        add_op(FN_TICK, 4'd0, 64'd100, 1'b0, '0, '0, '0, '0);
        add_op(FN_TICK, 4'd0, 64'd200, 1'b0, '0, '0, '0, '0);
        add_op(FN_READ, 4'd0, 64'd0, 1'b0, '0, '0, '0, '0);
        add_op(FN_READ, 4'd0, 64'd0, 1'b0, '0, '0, '0, '0);
        // zero value disarms but still writes the interval
        add_op(FN_SET, 4'd0, 64'd300, 1'b0, 34'd0, 30'd0, 34'd3, 30'd7);
        add_op(FN_SET, 4'd0, 64'd300, 1'b0, 34'd0, 30'd1, 34'd0, 30'd0);
        // relative expiry wrapping to zero
        add_op(FN_SET, 4'd15, 64'hFFFF_FFFF_FFFF_FFFB, 1'b0, 34'd0, 30'd5, 34'd0, 30'd1);
        add_op(FN_TICK, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0, '0, '0, '0);
        // rearm time wrapping to zero
        wrap_iv = sec_nsec_to_ns(34'd1, 30'd0);
        add_op(FN_SET, 4'd7, 64'd0, 1'b1, 34'd0, 30'd1, 34'd1, 30'd0);
        add_op(FN_TICK, 4'd0, 64'd0 - wrap_iv, 1'b0, '0, '0, '0, '0);
        add_op(FN_SET, 4'd7, 64'd0, 1'b1, 34'd0, 30'd0, 34'd0, 30'd0);
        // extremes and nanoseconds above one second
        add_op(FN_SET, 4'd9, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 34'h3_FFFF_FFFF, 30'h3FFF_FFFF,
               34'h3_FFFF_FFFF, 30'h3FFF_FFFF);
        add_op(FN_SET, 4'd9, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 34'h3_FFFF_FFFF, 30'h3FFF_FFFF,
               34'h3_FFFF_FFFF, 30'h3FFF_FFFF);
        add_op(FN_TICK, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0, '0, '0, '0);
        add_op(FN_READ, 4'd9, 64'd0, 1'b0, '0, '0, '0, '0);
        add_op(FN_NONE, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 34'h3_FFFF_FFFF,
               30'h3FFF_FFFF, 34'h3_FFFF_FFFF, 30'h3FFF_FFFF);
        add_op(FN_SET, 4'd9, 64'd0, 1'b1, 34'd0, 30'd0, 34'd0, 30'd0);
        add_op(FN_READ, 4'd15, 64'd0, 1'b0, '0, '0, '0, '0);

        // random traffic around a running clock so timers keep expiring
        run_ns = 64'd1000;
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                if ($urandom_range(0, 19) == 0)
                    add_op(FN_TICK, 4'($urandom), {$urandom, $urandom}, 1'($urandom),
                           34'({$urandom, $urandom}), 30'($urandom),
                           34'({$urandom, $urandom}), 30'($urandom));
                else
                begin
                    run_ns += 64'($urandom_range(0, 3000));
                    add_op(FN_TICK, 4'($urandom), run_ns, 1'b0, '0, '0, '0, '0);
                end
            end
            else if (pick < 72)
            begin
                if ($urandom_range(0, 3) == 0)
                    add_op(FN_SET, 4'($urandom), {$urandom, $urandom}, 1'($urandom),
                           34'({$urandom, $urandom}), 30'($urandom_range(0, 30'h3FFF_FFFF)),
                           34'({$urandom, $urandom}), 30'($urandom_range(0, 30'h3FFF_FFFF)));
                else
                    add_op(FN_SET, 4'($urandom), run_ns, 1'b0, 34'd0,
                           30'($urandom_range(0, 4000)), 34'd0,
                           ($urandom_range(0, 3) == 0) ? 30'd0 : 30'($urandom_range(1, 2500)));
            end
            else if (pick < 95)
                add_op(FN_READ, 4'($urandom), run_ns, 1'b0, '0, '0, '0, '0);
            else
                add_op(FN_NONE, 4'($urandom), {$urandom, $urandom}, 1'($urandom),
                       34'({$urandom, $urandom}), 30'($urandom),
                       34'({$urandom, $urandom}), 30'($urandom));
        end

        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_ops.size() == 0);
        @(posedge clk);
        while (s_tvalid)
            @(posedge clk);
        while (expected_replies.size() > 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
